[rtl/sfr_pkg.sv]
// Shared types and constants for the sensor frame receiver.
// No dependencies; used by sfr_divider and sensor_frame_receiver_core.
package sfr_pkg;

    localparam int unsigned FRAME_LEN = 17;
    // Bytes 1 to 15 are kept in the shift line; the check byte is not stored.
    localparam int unsigned SR_DEPTH  = FRAME_LEN - 2;
    localparam int unsigned POS_W     = $clog2(FRAME_LEN);
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LEN - 1);

    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_MARKER   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IR_SCALE     = 2'd2;

    localparam logic [7:0]  START_MARKER_RST = 8'hAA;
    localparam logic [7:0]  END_MARKER_RST   = 8'hFF;
    localparam logic [15:0] IR_SCALE_RST     = 16'd2914;

    localparam logic [15:0] SPEED_OFFSET    = 16'd1560;
    localparam logic [15:0] SPEED_FWD_ABOVE = 16'd1520;
    localparam logic [15:0] SPEED_REV_BELOW = 16'd1500;
    localparam logic [16:0] IR_RAW_BIAS     = 17'd5;
    localparam logic [15:0] IR_QUOT_LIMIT   = 16'd1024;

    localparam int unsigned DIV_W  = 16;
    localparam int unsigned DIVS_W = 17;

    typedef struct packed {
        logic busy;
        logic done;
    } sfr_div_stat_t;

endpackage

[rtl/sensor_frame_receiver_core.sv]
// Sensor frame receiver: one received byte is taken per cycle while hunting or collecting.
// After the last byte of a good 17-byte frame, three serial divisions run with the input
// stalled; the result word is then loaded into the output registers once any earlier word
// still held on the output is taken. A bad frame does not stall the input; the receiver
// goes straight back to hunting.
// Reset (aresetn, synchronous, active low) returns to hunting, restores config registers.
module sensor_frame_receiver_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [sfr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [15:0]                       cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [7:0]                        s_rx_byte,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [16:0]                m_speed_value,
    output logic [15:0]                       m_steering_raw,
    output logic signed [10:0]                m_ir_front_right_dist,
    output logic signed [10:0]                m_ir_middle_right_dist,
    output logic signed [10:0]                m_ir_back_dist,
    output logic [15:0]                       m_us_front,
    output logic [15:0]                       m_us_front_right
);

    typedef enum logic [3:0] {
        ST_HUNT    = 4'b0001,
        ST_COLLECT = 4'b0010,
        ST_DIVIDE  = 4'b0100,
        ST_LOAD    = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [7:0]  start_marker_reg;
    logic [7:0]  end_marker_reg;
    logic [15:0] ir_scale_reg;

    logic [sfr_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [7:0]                xor_reg, xor_next;
    logic [7:0]                frame_sr_reg [sfr_pkg::SR_DEPTH];
    logic                      shift_en;

    logic [1:0]                div_sel_reg, div_sel_next;
    logic                      div_start_reg, div_start_next;
    logic [10:0]               ir_sr_reg [3];
    logic                      ir_shift;
    logic [15:0]               ir_raw;
    logic [15:0]               quotient;
    logic [15:0]               quot_sat;
    logic [10:0]               ir_dist;
    sfr_pkg::sfr_div_stat_t    div_stat;

    logic                      m_valid_reg, m_valid_next;
    logic                      load_out;
    logic [15:0]               speed_raw;
    logic [16:0]               speed_val;

    logic                      in_acc;
    logic [7:0]                xor_all;

    assign s_ready = (state_reg == ST_HUNT) || (state_reg == ST_COLLECT);
    assign in_acc  = s_valid && s_ready;
    assign xor_all = xor_reg ^ s_rx_byte;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_marker_reg <= sfr_pkg::START_MARKER_RST;
            end_marker_reg   <= sfr_pkg::END_MARKER_RST;
            ir_scale_reg     <= sfr_pkg::IR_SCALE_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                sfr_pkg::CFG_START_MARKER: start_marker_reg <= cfg_wdata[7:0];
                sfr_pkg::CFG_END_MARKER:   end_marker_reg   <= cfg_wdata[7:0];
                sfr_pkg::CFG_IR_SCALE:     ir_scale_reg     <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        xor_next       = xor_reg;
        shift_en       = 1'b0;
        div_sel_next   = div_sel_reg;
        div_start_next = 1'b0;
        ir_shift       = 1'b0;
        load_out       = 1'b0;
        unique case (state_reg)
            ST_HUNT: begin
                if (in_acc && (s_rx_byte == start_marker_reg)) begin
                    xor_next   = s_rx_byte;
                    pos_next   = sfr_pkg::POS_W'(1);
                    state_next = ST_COLLECT;
                end
            end
            ST_COLLECT: begin
                if (in_acc) begin
                    if (pos_reg == sfr_pkg::LAST_POS) begin
                        xor_next = '0;
                        pos_next = '0;
                        if ((xor_all == 8'd0) &&
                            (frame_sr_reg[sfr_pkg::SR_DEPTH-1] == end_marker_reg)) begin
                            state_next     = ST_DIVIDE;
                            div_sel_next   = 2'd0;
                            div_start_next = 1'b1;
                        end else begin
                            state_next = ST_HUNT;
                        end
                    end else begin
                        shift_en = 1'b1;
                        xor_next = xor_all;
                        pos_next = pos_reg + sfr_pkg::POS_W'(1);
                    end
                end
            end
            ST_DIVIDE: begin
                if (div_stat.done) begin
                    ir_shift = 1'b1;
                    if (div_sel_reg == 2'd2) begin
                        state_next = ST_LOAD;
                    end else begin
                        div_sel_next   = div_sel_reg + 2'd1;
                        div_start_next = 1'b1;
                    end
                end
            end
            ST_LOAD: begin
                if (!m_valid_reg || m_ready) begin
                    load_out   = 1'b1;
                    state_next = ST_HUNT;
                end
            end
            default: state_next = ST_HUNT;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_HUNT;
            pos_reg       <= '0;
            xor_reg       <= '0;
            div_sel_reg   <= '0;
            div_start_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            xor_reg       <= xor_next;
            div_sel_reg   <= div_sel_next;
            div_start_reg <= div_start_next;
        end
    end

    // Frame bytes enter at the top and move down, so byte 1 ends in entry 0.
    always_ff @(posedge aclk) begin
        if (shift_en) begin
            for (int i = 0; i < sfr_pkg::SR_DEPTH - 1; i++) begin
                frame_sr_reg[i] <= frame_sr_reg[i+1];
            end
            frame_sr_reg[sfr_pkg::SR_DEPTH-1] <= s_rx_byte;
        end
    end

    always_comb begin
        unique case (div_sel_reg)
            2'd0:    ir_raw = {frame_sr_reg[5], frame_sr_reg[4]};
            2'd1:    ir_raw = {frame_sr_reg[7], frame_sr_reg[6]};
            default: ir_raw = {frame_sr_reg[9], frame_sr_reg[8]};
        endcase
    end

    sfr_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start_reg),
        .dividend (ir_scale_reg),
        .divisor  ({1'b0, ir_raw} + sfr_pkg::IR_RAW_BIAS),
        .quotient (quotient),
        .stat     (div_stat)
    );

    assign quot_sat = (quotient > sfr_pkg::IR_QUOT_LIMIT) ? sfr_pkg::IR_QUOT_LIMIT : quotient;
    assign ir_dist  = 11'(quot_sat - 16'd1);

    always_ff @(posedge aclk) begin
        if (ir_shift) begin
            ir_sr_reg[0] <= ir_sr_reg[1];
            ir_sr_reg[1] <= ir_sr_reg[2];
            ir_sr_reg[2] <= ir_dist;
        end
    end

    assign speed_raw = {frame_sr_reg[1], frame_sr_reg[0]};

    always_comb begin
        priority if (speed_raw > sfr_pkg::SPEED_FWD_ABOVE) begin
            speed_val = {1'b0, speed_raw} - {1'b0, sfr_pkg::SPEED_OFFSET};
        end else if (speed_raw < sfr_pkg::SPEED_REV_BELOW) begin
            speed_val = '1;
        end else begin
            speed_val = '0;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        if (load_out) begin
            m_speed_value          <= speed_val;
            m_steering_raw         <= {frame_sr_reg[3], frame_sr_reg[2]};
            m_ir_front_right_dist  <= ir_sr_reg[0];
            m_ir_middle_right_dist <= ir_sr_reg[1];
            m_ir_back_dist         <= ir_sr_reg[2];
            m_us_front             <= {frame_sr_reg[11], frame_sr_reg[10]};
            m_us_front_right       <= {frame_sr_reg[13], frame_sr_reg[12]};
        end
    end

    assign m_valid = m_valid_reg;

`ifndef SYNTHESIS
    a_div_idle_when_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !div_stat.busy)
        else $error("divider busy while input is open");

    a_done_in_divide: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |-> (state_reg == ST_DIVIDE))
        else $error("division finished outside the divide phase");

    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_COLLECT) |-> ((pos_reg != '0) && (pos_reg <= sfr_pkg::LAST_POS)))
        else $error("byte position out of range while collecting");

    a_load_after_divide: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_LOAD))
        else $error("result word raised without a finished frame");
`endif

endmodule

[rtl/sfr_divider.sv]
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on sfr_pkg for widths and the status struct.
module sfr_divider (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [sfr_pkg::DIV_W-1:0]       dividend,
    input  logic [sfr_pkg::DIVS_W-1:0]      divisor,
    output logic [sfr_pkg::DIV_W-1:0]       quotient,
    output sfr_pkg::sfr_div_stat_t          stat
);

    localparam int unsigned CNT_W = $clog2(sfr_pkg::DIV_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(sfr_pkg::DIV_W - 1);

    logic [sfr_pkg::DIV_W-1:0]  dvd_reg, dvd_next;
    logic [sfr_pkg::DIVS_W-1:0] dvs_reg, dvs_next;
    logic [sfr_pkg::DIVS_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;

    logic [sfr_pkg::DIVS_W:0]   trial;
    logic [sfr_pkg::DIVS_W:0]   diff;
    logic                       fits;

    assign trial = {rem_reg, dvd_reg[sfr_pkg::DIV_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb begin
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            dvd_next  = dividend;
            dvs_next  = divisor;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? diff[sfr_pkg::DIVS_W-1:0] : trial[sfr_pkg::DIVS_W-1:0];
            dvd_next = {dvd_reg[sfr_pkg::DIV_W-2:0], fits};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_LAST) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign quotient  = dvd_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule
